### rtl/core/sis_pkg.sv
package sis_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned STAT_W  = 2;

  localparam logic signed [DATA_W-1:0] EMPTY_MARK = 32'sd114;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic  ins;
    logic  pop;
    data_t val;
  } sis_cmd_t;

endpackage

### rtl/core/sis_if.sv
interface sis_in_if;
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic signed [31:0]   value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface sis_out_if;
  logic                 valid;
  logic                 ready;
  logic signed [31:0]   popped_value;
  logic [1:0]           status;
  logic [4:0]           entry_count;

  modport source (output valid, output popped_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input popped_value, input status, input entry_count,
                  output ready);
endinterface

### rtl/core/sis_cell.sv
module sis_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  sis_pkg::sis_cmd_t cmd,
  input  logic              prev_valid,
  input  logic              prev_ge,
  input  sis_pkg::data_t    prev_value,
  input  logic              next_valid,
  input  sis_pkg::data_t    next_value,
  output logic              valid_o,
  output logic              ge_o,
  output sis_pkg::data_t    value_o
);
  import sis_pkg::*;

  logic  valid_r, valid_nxt;
  data_t value_r, value_nxt;

  assign ge_o    = valid_r && (value_r >= cmd.val);
  assign valid_o = valid_r;
  assign value_o = value_r;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (cmd.pop) begin
      valid_nxt = next_valid;
      value_nxt = next_value;
    end else if (cmd.ins) begin
      valid_nxt = valid_r | prev_valid;
      if (!ge_o) begin
        value_nxt = prev_ge ? cmd.val : prev_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

### rtl/core/sorted_insert_stack_core.sv
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one insert or pop per cycle unless the output stalls; every cell
// compares against the new value in parallel and shifts one place in the same cycle.
// Reset (synchronous, active low) empties the store and drops any pending result.
// Cell contents are not cleared; only the occupancy bits are.
module sorted_insert_stack_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  sis_in_if.sink         in_ch,
  sis_out_if.source      out_ch
);
  import sis_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sis_cmd_t          cmd;
  logic [DEPTH-1:0]  cell_valid;
  logic [DEPTH-1:0]  cell_ge;
  data_t             cell_value [DEPTH];

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W+4:0]  count_ext;
  logic              accept, full, empty;

  logic              out_valid_r;
  data_t             popped_r, popped_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [COUNT_W-1:0] entry_r;

  assign full   = cell_valid[DEPTH-1];
  assign empty  = !cell_valid[0];
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;

  assign cmd.ins = accept && !in_ch.action && !full;
  assign cmd.pop = accept && in_ch.action && !empty;
  assign cmd.val = in_ch.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic  p_valid, p_ge, n_valid;
    data_t p_value, n_value;

    if (i == 0) begin : g_first
      assign p_valid = 1'b1;
      assign p_ge    = 1'b1;
      assign p_value = cmd.val;
    end else begin : g_mid
      assign p_valid = cell_valid[i-1];
      assign p_ge    = cell_ge[i-1];
      assign p_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign n_valid = 1'b0;
      assign n_value = '0;
    end else begin : g_inner
      assign n_valid = cell_valid[i+1];
      assign n_value = cell_value[i+1];
    end

    sis_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .prev_valid (p_valid),
      .prev_ge    (p_ge),
      .prev_value (p_value),
      .next_valid (n_valid),
      .next_value (n_value),
      .valid_o    (cell_valid[i]),
      .ge_o       (cell_ge[i]),
      .value_o    (cell_value[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    popped_nxt = '0;
    status_nxt = ST_OK;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt  = count_r - CNT_W'(1);
      popped_nxt = cell_value[0];
    end
    if (in_ch.action && empty) begin
      popped_nxt = EMPTY_MARK;
      status_nxt = ST_EMPTY;
    end else if (!in_ch.action && full) begin
      status_nxt = ST_FULL;
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r <= popped_nxt;
      status_r <= status_nxt;
      entry_r  <= count_ext[COUNT_W-1:0];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_value = popped_r;
  assign out_ch.status       = status_r;
  assign out_ch.entry_count  = entry_r;

  a_empty_matches_count : assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) == empty)
    else $error("Occupancy of the first cell disagrees with the count.");

  a_count_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("Count exceeds the depth.");

  a_full_matches_count : assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CNT_W'(DEPTH)) == full)
    else $error("Occupancy of the last cell disagrees with the count.");

  a_top_sorted : assert property (@(posedge clk) disable iff (!rst_n)
    cell_valid[1] |-> (cell_value[0] >= cell_value[1] && cell_valid[0]))
    else $error("The two topmost cells are out of order.");

  a_pop_shrinks : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("A pop did not reduce the count by one.");

endmodule

### sim/sorted_insert_stack_core_tb.sv
`timescale 1ns / 100ps

module sorted_insert_stack_core_tb;
  import sis_pkg::*;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned RANDOM_OPS = 880;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES = 8;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  typedef struct packed {
    logic  action;
    data_t value;
  } stack_op_t;

  typedef struct packed {
    data_t              popped_value;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] entry_count;
  } stack_result_t;

  logic clk;
  logic rst_n;

  sis_in_if  in_ch ();
  sis_out_if out_ch ();

  sorted_insert_stack_core #(
    .DEPTH(STACK_DEPTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  stack_op_t     pending_ops[$];
  stack_result_t expected_results[$];

  data_t stack_cells[STACK_DEPTH];
  int    stack_fill;

  int  sent_count;
  int  accepted_count;
  int  checked_count;
  int  fail_count;
  int  empty_pops;
  int  full_inserts;
  int  hold_left;
  bit  hold_done;
  bit  in_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results still outstanding.", expected_results.size());
    $display("FAIL");
    $finish;
  end

  function automatic int traffic_phase(input int beats_sent);
    if (beats_sent < 300) begin
      return 0;
    end else if (beats_sent < 600) begin
      return 1;
    end
    return 2;
  endfunction

  function automatic stack_result_t apply_stack_op(input logic action, input data_t value);
    stack_result_t res;
    int            slot;
    res.popped_value = '0;
    res.status       = ST_OK;
    if (action == ACT_POP) begin
      if (stack_fill == 0) begin
        res.popped_value = EMPTY_MARK;
        res.status       = ST_EMPTY;
        empty_pops++;
      end else begin
        stack_fill--;
        res.popped_value = stack_cells[stack_fill];
      end
    end else if (stack_fill >= STACK_DEPTH) begin
      res.status = ST_FULL;
      full_inserts++;
    end else begin
      slot = stack_fill;
      while (slot > 0 && stack_cells[slot-1] >= value) begin
        stack_cells[slot] = stack_cells[slot-1];
        slot--;
      end
      stack_cells[slot] = value;
      stack_fill++;
    end
    res.entry_count = stack_fill[COUNT_W-1:0];
    return res;
  endfunction

  task automatic queue_op(input logic action, input data_t value);
    stack_op_t op;
    op.action = action;
    op.value  = value;
    pending_ops.push_back(op);
  endtask

  function automatic data_t pick_value();
    data_t v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $signed($urandom_range(8)) - 4;
      2: begin
        case ($urandom_range(3))
          0: v = 32'sh7fffffff;
          1: v = 32'sh80000000;
          2: v = -1;
          default: v = 0;
        endcase
      end
      default: v = $signed($urandom_range(2000)) - 1000;
    endcase
    return v;
  endfunction

  always @(negedge clk) begin
    int idle_pct;
    stack_op_t op;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      case (traffic_phase(sent_count))
        0: idle_pct = 15;
        1: idle_pct = 77;
        default: idle_pct = 0;
      endcase
      if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct) begin
        op = pending_ops.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.action <= op.action;
        in_ch.value  <= op.value;
        sent_count++;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // The long hold-off in the last phase lets the block fill and stall its input.
  always @(negedge clk) begin
    int idle_pct;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (traffic_phase(sent_count) == 2 && !hold_done && sent_count >= 650) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      case (traffic_phase(sent_count))
        0: idle_pct = 77;
        1: idle_pct = 15;
        default: idle_pct = 0;
      endcase
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    stack_result_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(apply_stack_op(in_ch.action, in_ch.value));
        accepted_count++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("Result beat arrived with nothing expected.");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          checked_count++;
          if (out_ch.popped_value !== want.popped_value) begin
            $error("popped_value: expected %0d, got %0d", want.popped_value,
                   out_ch.popped_value);
            fail_count++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            fail_count++;
          end
          if (out_ch.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_ch.entry_count);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    int   burst_len;
    int   pop_pct;
    int   n;
    logic action;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_INSERT;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    stack_fill   = 0;
    sent_count   = 0;
    accepted_count = 0;
    checked_count  = 0;
    fail_count   = 0;
    empty_pops   = 0;
    full_inserts = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    in_taken     = 1'b0;

    queue_op(ACT_POP, 32'sh7fffffff);
    queue_op(ACT_INSERT, 32'sh7fffffff);
    queue_op(ACT_INSERT, 32'sh80000000);
    queue_op(ACT_INSERT, 0);
    queue_op(ACT_INSERT, -1);
    queue_op(ACT_INSERT, 1);
    queue_op(ACT_INSERT, 0);
    queue_op(ACT_INSERT, 5);
    queue_op(ACT_INSERT, 5);
    queue_op(ACT_INSERT, 5);
    queue_op(ACT_INSERT, 114);
    queue_op(ACT_INSERT, -114);
    queue_op(ACT_INSERT, 32'sh55555555);
    queue_op(ACT_INSERT, 32'shaaaaaaaa);
    queue_op(ACT_INSERT, 100);
    queue_op(ACT_INSERT, -100);
    queue_op(ACT_INSERT, 7);
    queue_op(ACT_INSERT, 42);
    queue_op(ACT_POP, 32'sh80000000);
    queue_op(ACT_POP, -1);
    queue_op(ACT_POP, 0);
    queue_op(ACT_POP, 32'sh55555555);
    queue_op(ACT_POP, 32'shaaaaaaaa);

    // Bursts lean towards inserts or pops so that both the full and the empty
    // store are reached many times.
    n = 0;
    while (n < RANDOM_OPS) begin
      burst_len = $urandom_range(40, 4);
      case ($urandom_range(2))
        0: pop_pct = 20;
        1: pop_pct = 80;
        default: pop_pct = 50;
      endcase
      repeat (burst_len) begin
        action = ($urandom_range(99) < pop_pct) ? ACT_POP : ACT_INSERT;
        queue_op(action, pick_value());
        n++;
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_ch.valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d beats and checked %0d results across three handshake phases.",
             accepted_count, checked_count);
    $display("Pops on an empty store: %0d; inserts dropped on a full store: %0d.",
             empty_pops, full_inserts);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/sis_pkg.sv
rtl/core/sis_if.sv
rtl/core/sis_cell.sv
rtl/core/sorted_insert_stack_core.sv
sim/sorted_insert_stack_core_tb.sv
